### hw/rtl/dominant_palette_color_picker_core_defines.svh
// Assertion macros shared by the color picker RTL.
`ifndef DOMINANT_PALETTE_COLOR_PICKER_CORE_DEFINES_SVH
`define DOMINANT_PALETTE_COLOR_PICKER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define DPCP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define DPCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/dpcp_pkg.sv
// Shared constants and codes for the dominant palette color picker.
`timescale 1ns / 1ps

package dpcp_pkg;

	localparam int MAX_SIDE_DEF = 100;
	localparam int SIDE_W       = 7;
	localparam int PIX_W        = 8;
	localparam int HIST_W       = 14;
	localparam int BINS         = 256;

	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BOOK   = 2'd2;

	localparam logic [PIX_W-1:0] COLOR_BLACK = 8'd0;
	localparam logic [PIX_W-1:0] COLOR_WHITE = 8'd255;
	localparam logic [PIX_W-1:0] COLOR_DFLT  = 8'd254;
	localparam logic [PIX_W-1:0] COLOR_FIRST = 8'd1;

endpackage

### hw/rtl/dpcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dpcp_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns old data when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/dominant_palette_color_picker_core.sv
// Top level of the dominant palette color picker: histogram, core pick, result.
//
//  channel   dir  handshake               payload
//  s_*       in   s_tvalid / s_tready     s_tuser[0] command, s_tdata[7:0] pixel_value
//  m_*       out  m_tvalid / m_tready     m_tdata: text, outline, used_default, core_found
//  apb       in   psel/penable, pready=1  paddr 4*i: width, height, book_mode
//
// One request per cycle while s_tready is high. A pixel reads its bin from the histogram
// RAM and writes it back in the next cycle; a back-to-back hit on the same bin is forwarded.
// The most frequent non-black, non-white color is tracked on every write, so m_tvalid rises at
// the edge after the one that takes a frame's last pixel, and at the edge of an invalid begin.
// s_tready drops for the cycle after a last pixel, and while a result waits with m_tready low.
// Begin clears all per-bin valid flags in parallel; no clearing pass after reset.
`timescale 1ns / 1ps
`include "dominant_palette_color_picker_core_defines.svh"

module dominant_palette_color_picker_core #(
	parameter int MAX_SIDE = dpcp_pkg::MAX_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel_value
	input  logic [0:0]  s_tuser,   // [0] command
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] text_color, [15:8] outline_color,
	                               // [16] used_default, [17] core_found, [23:18] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SW = dpcp_pkg::SIDE_W;
	localparam int PW = dpcp_pkg::PIX_W;
	localparam int HW = dpcp_pkg::HIST_W;
	localparam int NB = dpcp_pkg::BINS;
	localparam logic [SW-1:0] SIDE_MAX = SW'(MAX_SIDE);

	// configuration registers
	logic [SW-1:0] cfg_w_q, cfg_h_q;
	logic          cfg_book_q;
	logic          cfg_wr;

	// frame state
	logic          frame_active_q;
	logic [SW-1:0] lat_w_q, lat_h_q;
	logic          lat_book_q;
	logic [SW-1:0] row_q, col_q;
	logic [SW-1:0] row_lo_q, row_hi_q, col_lo_q, col_hi_q;
	logic [PW-1:0] core_pix_q;
	logic          core_seen_q;

	// histogram pipeline
	logic [NB-1:0] bin_vld_q;
	logic          s1_vld_q, s1_last_q;
	logic [PW-1:0] s1_addr_s1;
	logic          fwd_vld_q;
	logic [PW-1:0] fwd_addr_q;
	logic [HW-1:0] fwd_cnt_q;
	logic [HW-1:0] best_cnt_q;
	logic [PW-1:0] best_col_q;
	logic [HW-1:0] ram_rdata, old_cnt, new_cnt;
	logic          best_upd;
	logic [HW-1:0] best_cnt_nx;
	logic [PW-1:0] best_col_nx;

	// output register
	logic          out_vld_q;
	logic [PW-1:0] out_text_q, out_outline_q;
	logic          out_dflt_q, out_core_q;

	logic          acc, is_begin, is_pix, size_bad, out_free;
	logic [PW-1:0] pix;
	logic [8:0]    w3, h3;
	logic          in_core, col_end, row_end, fin_now;
	logic [PW-1:0] fin_text;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			dpcp_pkg::REG_WIDTH:  prdata = 32'(cfg_w_q);
			dpcp_pkg::REG_HEIGHT: prdata = 32'(cfg_h_q);
			dpcp_pkg::REG_BOOK:   prdata = 32'(cfg_book_q);
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q    <= '0;
			cfg_h_q    <= '0;
			cfg_book_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				dpcp_pkg::REG_WIDTH:  cfg_w_q    <= pwdata[SW-1:0];
				dpcp_pkg::REG_HEIGHT: cfg_h_q    <= pwdata[SW-1:0];
				dpcp_pkg::REG_BOOK:   cfg_book_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// input side
	assign out_free = !out_vld_q || m_tready;
	assign s_tready = out_free && !(s1_vld_q && s1_last_q);
	assign acc      = s_tvalid && s_tready;
	assign pix      = s_tdata[PW-1:0];
	assign is_begin = acc && (s_tuser[0] == dpcp_pkg::CMD_BEGIN);
	assign is_pix   = acc && (s_tuser[0] == dpcp_pkg::CMD_PIXEL) && frame_active_q;
	assign size_bad = (cfg_w_q == '0) || (cfg_h_q == '0) ||
	                  (cfg_w_q > SIDE_MAX) || (cfg_h_q > SIDE_MAX);
	assign w3 = 9'(cfg_w_q) * 9'd3;
	assign h3 = 9'(cfg_h_q) * 9'd3;

	assign in_core = !core_seen_q && (pix != dpcp_pkg::COLOR_BLACK) &&
	                 (pix != dpcp_pkg::COLOR_WHITE) &&
	                 (row_q >= row_lo_q) && (row_q < row_hi_q) &&
	                 (col_q >= col_lo_q) && (col_q < col_hi_q);
	assign col_end = ({1'b0, col_q} + 8'd1) >= {1'b0, lat_w_q};
	assign row_end = ({1'b0, row_q} + 8'd1) >= {1'b0, lat_h_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_active_q <= 1'b0;
			lat_w_q        <= '0;
			lat_h_q        <= '0;
			lat_book_q     <= 1'b0;
			row_q          <= '0;
			col_q          <= '0;
			row_lo_q       <= '0;
			row_hi_q       <= '0;
			col_lo_q       <= '0;
			col_hi_q       <= '0;
			core_pix_q     <= '0;
			core_seen_q    <= 1'b0;
			s1_vld_q       <= 1'b0;
			s1_last_q      <= 1'b0;
		end else begin
			s1_vld_q <= is_pix;
			if (is_pix) begin
				s1_last_q <= col_end && row_end;
			end
			if (is_begin) begin
				frame_active_q <= !size_bad;
				lat_w_q        <= cfg_w_q;
				lat_h_q        <= cfg_h_q;
				lat_book_q     <= cfg_book_q;
				row_q          <= '0;
				col_q          <= '0;
				col_lo_q       <= cfg_w_q >> 2;
				row_lo_q       <= cfg_h_q >> 2;
				col_hi_q       <= w3[8:2];
				row_hi_q       <= h3[8:2];
				core_pix_q     <= '0;
				core_seen_q    <= 1'b0;
			end else if (is_pix) begin
				if (in_core) begin
					core_pix_q  <= pix;
					core_seen_q <= 1'b1;
				end
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q          <= '0;
						frame_active_q <= 1'b0;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_pix) begin
			s1_addr_s1 <= pix;
		end
	end

	dpcp_ram #(
		.WIDTH(HW),
		.DEPTH(NB)
	) u_hist (
		.clk  (clk),
		.we   (s1_vld_q),
		.waddr(s1_addr_s1),
		.wdata(new_cnt),
		.re   (is_pix),
		.raddr(pix),
		.rdata(ram_rdata)
	);

	// read-modify-write: bin not yet written this frame reads as zero
	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == s1_addr_s1)) begin
			old_cnt = fwd_cnt_q;
		end else if (bin_vld_q[s1_addr_s1]) begin
			old_cnt = ram_rdata;
		end else begin
			old_cnt = '0;
		end
		new_cnt  = old_cnt + 1'b1;
		best_upd = (s1_addr_s1 != dpcp_pkg::COLOR_BLACK) &&
		           (s1_addr_s1 != dpcp_pkg::COLOR_WHITE) &&
		           ((new_cnt > best_cnt_q) ||
		            ((new_cnt == best_cnt_q) && (s1_addr_s1 < best_col_q)));
		best_cnt_nx = best_upd ? new_cnt : best_cnt_q;
		best_col_nx = best_upd ? s1_addr_s1 : best_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q  <= '0;
			fwd_vld_q  <= 1'b0;
			fwd_addr_q <= '0;
			fwd_cnt_q  <= '0;
			best_cnt_q <= '0;
			best_col_q <= dpcp_pkg::COLOR_FIRST;
		end else if (is_begin) begin
			bin_vld_q  <= '0;
			fwd_vld_q  <= 1'b0;
			best_cnt_q <= '0;
			best_col_q <= dpcp_pkg::COLOR_FIRST;
		end else begin
			fwd_vld_q <= s1_vld_q;
			if (s1_vld_q) begin
				bin_vld_q[s1_addr_s1] <= 1'b1;
				fwd_addr_q            <= s1_addr_s1;
				fwd_cnt_q             <= new_cnt;
				best_cnt_q            <= best_cnt_nx;
				best_col_q            <= best_col_nx;
			end
		end
	end

	// result
	assign fin_now = s1_vld_q && s1_last_q;

	always_comb begin
		if (core_seen_q) begin
			fin_text = core_pix_q;
		end else if (lat_book_q) begin
			fin_text = dpcp_pkg::COLOR_WHITE;
		end else if (best_cnt_nx != '0) begin
			fin_text = best_col_nx;
		end else begin
			fin_text = dpcp_pkg::COLOR_DFLT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((is_begin && size_bad) || fin_now) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_begin && size_bad) begin
			out_text_q    <= cfg_book_q ? dpcp_pkg::COLOR_WHITE : dpcp_pkg::COLOR_DFLT;
			out_outline_q <= cfg_book_q ? dpcp_pkg::COLOR_BLACK : dpcp_pkg::COLOR_WHITE;
			out_dflt_q    <= 1'b1;
			out_core_q    <= 1'b0;
		end else if (fin_now) begin
			out_text_q    <= fin_text;
			out_outline_q <= lat_book_q ? dpcp_pkg::COLOR_BLACK : dpcp_pkg::COLOR_WHITE;
			out_dflt_q    <= 1'b0;
			out_core_q    <= core_seen_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'b0, out_core_q, out_dflt_q, out_outline_q, out_text_q};

	`DPCP_ASSERT_NEXT(a_last_loads_out, fin_now, m_tvalid, "frame result not registered")
	`DPCP_ASSERT_NOW(a_pos_in_frame, frame_active_q,
		(col_q < lat_w_q) && (row_q < lat_h_q), "pixel position outside frame")
	`DPCP_ASSERT_NOW(a_fwd_bin_valid, fwd_vld_q, bin_vld_q[fwd_addr_q],
		"forwarded bin not marked written")
	`DPCP_ASSERT_NEXT(a_begin_flush, is_begin, !s1_vld_q && !fwd_vld_q && (best_cnt_q == '0),
		"histogram pipeline not flushed by begin")

endmodule

### sim/dominant_palette_color_picker_checker.sv
// Checker for the color picker: predicts each pick from the request stream and compares results.
`timescale 1ns / 1ps

module dominant_palette_color_picker_checker
	import dpcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel_value
	input  logic [0:0]  s_tuser,   // [0] command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [7:0] text, [15:8] outline, [16] used_default, [17] core_found
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic             core_found;
		logic             used_default;
		logic [PIX_W-1:0] outline;
		logic [PIX_W-1:0] text;
	} pick_t;

	pick_t             picks_due[$];
	logic [HIST_W-1:0] bin_count [BINS];
	logic [SIDE_W-1:0] cfg_w, cfg_h, frm_w, frm_h, row, col;
	logic              cfg_book, frm_book, core_hit, in_frame;
	logic [PIX_W-1:0]  core_pix;
	int                errors = 0;

	assign fail_count = errors;

	task automatic predict_pick(input logic cmd, input logic [PIX_W-1:0] pix);
		int                r, c, w, h;
		logic [HIST_W-1:0] top_count;
		logic [PIX_W-1:0]  top_pix;
		logic [PIX_W-1:0]  text;
		r = row;
		c = col;
		w = frm_w;
		h = frm_h;
		if (cmd == CMD_BEGIN) begin
			foreach (bin_count[i]) bin_count[i] = '0;
			row = '0;
			col = '0;
			core_pix = '0;
			core_hit = 1'b0;
			frm_w = cfg_w;
			frm_h = cfg_h;
			frm_book = cfg_book;
			if (cfg_w == 0 || cfg_h == 0 || cfg_w > MAX_SIDE_DEF || cfg_h > MAX_SIDE_DEF) begin
				in_frame = 1'b0;
				if (cfg_book)
					picks_due.push_back(pick_t'{1'b0, 1'b1, COLOR_BLACK, COLOR_WHITE});
				else
					picks_due.push_back(pick_t'{1'b0, 1'b1, COLOR_WHITE, COLOR_DFLT});
			end else begin
				in_frame = 1'b1;
			end
		end else if (in_frame) begin
			bin_count[pix] = bin_count[pix] + 1'b1;
			// core: first non-black, non-white pixel in the central half
			if (!core_hit && pix != COLOR_BLACK && pix != COLOR_WHITE &&
			    r >= h / 4 && r < (h * 3) / 4 && c >= w / 4 && c < (w * 3) / 4) begin
				core_pix = pix;
				core_hit = 1'b1;
			end
			if (c + 1 >= w) begin
				col = '0;
				if (r + 1 >= h) begin
					row = '0;
					in_frame = 1'b0;
					top_count = bin_count[COLOR_FIRST];
					top_pix = COLOR_FIRST;
					for (int i = COLOR_FIRST + 1; i <= COLOR_DFLT; i++) begin
						if (bin_count[i] > top_count) begin
							top_count = bin_count[i];
							top_pix = i[PIX_W-1:0];
						end
					end
					if (frm_book) begin
						text = core_hit ? core_pix : COLOR_WHITE;
						picks_due.push_back(pick_t'{core_hit, 1'b0, COLOR_BLACK, text});
					end else begin
						text = core_hit ? core_pix : (top_count > 0 ? top_pix : COLOR_DFLT);
						picks_due.push_back(pick_t'{core_hit, 1'b0, COLOR_WHITE, text});
					end
				end else begin
					row = row + 1'b1;
				end
			end else begin
				col = col + 1'b1;
			end
		end
	endtask

	task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch: expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pick_t got, want;
		if (!arst_n) begin
			picks_due.delete();
			foreach (bin_count[i]) bin_count[i] = '0;
			cfg_w = '0;
			cfg_h = '0;
			cfg_book = 1'b0;
			frm_w = '0;
			frm_h = '0;
			frm_book = 1'b0;
			row = '0;
			col = '0;
			core_pix = '0;
			core_hit = 1'b0;
			in_frame = 1'b0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_WIDTH:  cfg_w = pwdata[SIDE_W-1:0];
					REG_HEIGHT: cfg_h = pwdata[SIDE_W-1:0];
					REG_BOOK:   cfg_book = pwdata[0];
					default:    ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_pick(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready) begin
				got = m_tdata[17:0];
				if (picks_due.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected pick: expected none, got %h", $time, m_tdata);
				end else begin
					want = picks_due.pop_front();
					flag_field("text_color", want.text, got.text);
					flag_field("outline_color", want.outline, got.outline);
					flag_field("used_default", 8'(want.used_default), 8'(got.used_default));
					flag_field("core_found", 8'(want.core_found), 8'(got.core_found));
					flag_field("padding", '0, 8'(m_tdata[23:18]));
				end
			end
			pending <= picks_due.size();
		end
	end

endmodule

### sim/dominant_palette_color_picker_core_test.sv
// Testbench top for the color picker: drives requests, configuration and back-pressure.
`timescale 1ns / 1ps

module dominant_palette_color_picker_core_test;
	import dpcp_pkg::*;

	localparam int HOLD_CYCLES = 160;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] pixel_value
	logic [0:0]  s_tuser = '0;   // [0] command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [7:0] text, [15:8] outline, [16] used_default, [17] core_found
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          send_idle = 0;
	int          recv_stall = 0;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;

	dominant_palette_color_picker_core u_dut (.*);

	dominant_palette_color_picker_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic send_request(input logic cmd, input logic [7:0] pix);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(input int w, input int h, input logic book);
		wait_drained();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_BOOK, 32'(book));
	endtask

	function automatic logic [7:0] pick_pixel(input logic [7:0] hue [3]);
		case ($urandom_range(9))
			0:       return COLOR_BLACK;
			1:       return COLOR_WHITE;
			2:       return COLOR_FIRST;
			3:       return COLOR_DFLT;
			4, 5:    return 8'($urandom);
			default: return hue[$urandom_range(2)];
		endcase
	endfunction

	// groups of frames under one setting; the first group is a full-width or full-height strip
	task automatic run_random(input int budget, input bit tall);
		int         used, w, h, frames, cells, cut, kind;
		logic       book;
		logic [7:0] hue [3];
		used = 0;
		w = tall ? 1 : MAX_SIDE_DEF;
		h = tall ? MAX_SIDE_DEF : 1;
		book = ($urandom_range(1) == 1);
		while (used < budget) begin
			configure(w, h, book);
			frames = (w * h > 30) ? 1 : $urandom_range(1, 3);
			repeat (frames) begin
				send_request(CMD_BEGIN, 8'($urandom));
				used++;
				cells = (w == 0 || h == 0 || w > MAX_SIDE_DEF || h > MAX_SIDE_DEF) ? 0 : w * h;
				cut = ($urandom_range(9) == 0 && cells > 1) ? $urandom_range(1, cells - 1) : cells;
				foreach (hue[i]) hue[i] = 8'($urandom);
				for (int k = 0; k < cut; k++)
					send_request(CMD_PIXEL, pick_pixel(hue));
				used += cut;
				if ($urandom_range(7) == 0)
					send_request(CMD_PIXEL, 8'($urandom));
			end
			kind = $urandom_range(99);
			w = $urandom_range(1, 5);
			h = $urandom_range(1, 5);
			if (kind < 12) begin
				if ($urandom_range(1))
					w = $urandom_range(1) ? 0 : $urandom_range(MAX_SIDE_DEF + 1, 127);
				else
					h = $urandom_range(1) ? 0 : $urandom_range(MAX_SIDE_DEF + 1, 127);
			end else if (kind < 30) begin
				w = $urandom_range(1, 9);
				h = $urandom_range(1, 9);
			end
			book = ($urandom_range(3) == 0);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size is invalid; a pixel with no frame is dropped
		send_request(CMD_BEGIN, 8'hA5);
		send_request(CMD_PIXEL, 8'h5A);
		configure(0, 0, 1'b1);
		send_request(CMD_BEGIN, 8'h00);
		configure(127, 5, 1'b0);
		send_request(CMD_BEGIN, 8'hFF);
		configure(5, 101, 1'b0);
		send_request(CMD_BEGIN, 8'h00);
		// single pixel: black, white, then an ordinary color outside any core region
		configure(1, 1, 1'b0);
		send_request(CMD_BEGIN, 8'h00);
		send_request(CMD_PIXEL, COLOR_BLACK);
		send_request(CMD_BEGIN, 8'h00);
		send_request(CMD_PIXEL, COLOR_WHITE);
		send_request(CMD_BEGIN, 8'h00);
		send_request(CMD_PIXEL, 8'd7);
		// tie goes to the lower index
		configure(1, 4, 1'b0);
		send_request(CMD_BEGIN, 8'h00);
		send_request(CMD_PIXEL, 8'd9);
		send_request(CMD_PIXEL, 8'd3);
		send_request(CMD_PIXEL, 8'd9);
		send_request(CMD_PIXEL, 8'd3);
		// book mode: core found, abandoned frame, no core
		configure(2, 2, 1'b1);
		send_request(CMD_BEGIN, 8'h00);
		send_request(CMD_PIXEL, 8'd200);
		send_request(CMD_PIXEL, COLOR_BLACK);
		send_request(CMD_PIXEL, COLOR_BLACK);
		send_request(CMD_PIXEL, COLOR_BLACK);
		send_request(CMD_BEGIN, 8'h00);
		send_request(CMD_PIXEL, 8'd5);
		send_request(CMD_BEGIN, 8'h00);
		send_request(CMD_PIXEL, COLOR_BLACK);
		send_request(CMD_PIXEL, COLOR_WHITE);
		send_request(CMD_PIXEL, COLOR_BLACK);
		send_request(CMD_PIXEL, COLOR_BLACK);

		// long receiver hold-off while invalid begins wait behind a held result
		configure(0, 7, 1'b0);
		hold_req <= 1'b1;
		repeat (8) send_request(CMD_BEGIN, 8'($urandom));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle = 0;
					recv_stall <= 0;
				end
				1: begin
					send_idle = 47;
					recv_stall <= 0;
				end
				2: begin
					send_idle = 0;
					recv_stall <= 47;
				end
				default: begin
					send_idle = 37;
					recv_stall <= 37;
				end
			endcase
			run_random(125, ph[0]);
		end

		wait_drained();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
